### hdl/bwfa_pkg.sv
// ----------------------------------------------------------------------------
// bwfa_pkg
// Shared types, codes and defaults of the best/worst fit page allocator.
// ----------------------------------------------------------------------------
package bwfa_pkg;

   localparam int PAGES_DEF   = 32;
   localparam int PAGE_KB_DEF = 4;

   localparam int KIND_W   = 2;
   localparam int ID_W     = 8;
   localparam int SIZE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int PAGE_W   = 6;
   localparam int RUNS_W   = 5;
   localparam int FRAG_W   = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD   = 2'd0,
      KIND_KILL  = 2'd1,
      KIND_QUERY = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_SIZE  = 3'd1,
      STATUS_RUNNING   = 3'd2,
      STATUS_NO_SPACE  = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_DIV,
      ENG_SCAN,
      ENG_LAST,
      ENG_WRITE,
      ENG_DONE
   } eng_state_type;

   typedef struct packed {
      kind_type          kind;
      logic [ID_W-1:0]   prog_id;
      logic [SIZE_W-1:0] size_kb;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [PAGE_W-1:0]   start_page;
      logic [PAGE_W-1:0]   page_count;
      logic [RUNS_W-1:0]   free_runs;
      logic [FRAG_W-1:0]   internal_frag_kb;
   } rsp_type;

   // one entry of the page table memory
   typedef struct packed {
      logic            used;
      logic [ID_W-1:0] owner;
   } page_entry_type;

   // top level to engine
   typedef struct packed {
      logic start;
      logic take;
      logic fit_mode;
   } eng_ctl_type;

   // engine to top level
   typedef struct packed {
      logic ready;
      logic done;
   } eng_stat_type;

endpackage

### hdl/bwfa_ram.sv
// ----------------------------------------------------------------------------
// bwfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bwfa_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/bwfa_div.sv
// ----------------------------------------------------------------------------
// bwfa_div
// Page-size divider: quotient and remainder of a request size by the page
// size, by reciprocal multiplication, registered in the cycle after start.
// ----------------------------------------------------------------------------
module bwfa_div
   import bwfa_pkg::*;
#(
   parameter int PAGE_KB = PAGE_KB_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [SIZE_W-1:0]            dividend,
   output logic                         done,
   output logic [SIZE_W-1:0]            quot,
   output logic [$clog2(PAGE_KB):0]     rem
);

   localparam int RemW  = $clog2(PAGE_KB) + 1;
   // shift of the reciprocal: exact for every dividend of SIZE_W bits
   localparam int Shift = SIZE_W + $clog2(PAGE_KB);
   localparam int MulW  = SIZE_W + 2;
   localparam int ProdW = SIZE_W + MulW;
   localparam logic [MulW-1:0] Recip =
      MulW'(((64'd1 << Shift) + 64'(PAGE_KB) - 64'd1) / 64'(PAGE_KB));

   logic              done_ff, done_in;
   logic [SIZE_W-1:0] q_ff, q_in;
   logic [RemW-1:0]   r_ff, r_in;
   logic [ProdW-1:0]  prod;
   logic [ProdW-1:0]  back;
   logic [SIZE_W-1:0] q_now;
   logic [RemW-1:0]   r_now;

   // quotient from the reciprocal, remainder from the product back
   assign prod  = ProdW'(dividend) * ProdW'(Recip);
   assign q_now = SIZE_W'(prod >> Shift);
   assign back  = ProdW'(q_now) * ProdW'(PAGE_KB);
   assign r_now = RemW'(ProdW'(dividend) - back);

   assign done_in = start;
   assign q_in    = start ? q_now : q_ff;
   assign r_in    = start ? r_now : r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff;

endmodule

### hdl/bwfa_engine.sv
// ----------------------------------------------------------------------------
// bwfa_engine
// Request sequencer: scans the page table memory, places or frees programs.
// ----------------------------------------------------------------------------
module bwfa_engine
   import bwfa_pkg::*;
#(
   parameter int PAGES   = PAGES_DEF,
   parameter int PAGE_KB = PAGE_KB_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  eng_ctl_type  ctl,
   input  req_type      req,
   output eng_stat_type stat,
   output rsp_type      result
);

   localparam int IdxW  = $clog2(PAGES);
   localparam int CntW  = $clog2(PAGES + 1);
   localparam int RemW  = $clog2(PAGE_KB) + 1;
   localparam int NeedW = SIZE_W + 1;
   localparam int CmpW  = (CntW > NeedW) ? CntW : NeedW;
   localparam int unsigned MaxKb = PAGES * PAGE_KB;

   eng_state_type state_ff, state_in;

   req_type           req_ff, req_in;
   logic              bad_ff, bad_in;
   logic [NeedW-1:0]  need_ff, need_in;
   logic [FRAG_W-1:0] frag_ff, frag_in;

   logic [CntW-1:0]   rd_idx_ff, rd_idx_in;
   logic              dv_ff, dv_in;
   logic [IdxW-1:0]   d_idx_ff, d_idx_in;
   logic              d_last_ff, d_last_in;

   logic              prev_used_ff, prev_used_in;
   logic [IdxW-1:0]   run_start_ff, run_start_in;
   logic [CntW-1:0]   run_len_ff, run_len_in;
   logic [CntW-1:0]   runs_ff, runs_in;
   logic              found_ff, found_in;
   logic [IdxW-1:0]   best_start_ff, best_start_in;
   logic [CntW-1:0]   best_len_ff, best_len_in;
   logic              present_ff, present_in;
   logic [CntW-1:0]   kcount_ff, kcount_in;
   logic [IdxW-1:0]   kstart_ff, kstart_in;

   logic [IdxW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CntW-1:0]   wr_left_ff, wr_left_in;

   status_type        status_ff, status_in;
   logic [PAGE_W-1:0] start_pg_ff, start_pg_in;
   logic [PAGE_W-1:0] count_ff, count_in;
   logic [RUNS_W-1:0] runs_out_ff, runs_out_in;

   logic [PAGES-1:0]  valid_ff;

   // memory and divider hookup
   logic              ram_wr_en;
   logic [IdxW-1:0]   ram_wr_addr;
   page_entry_type    ram_wr_data;
   logic [IdxW-1:0]   ram_rd_addr;
   page_entry_type    rd_entry;
   logic              div_start;
   logic              div_done;
   logic [SIZE_W-1:0] div_quot;
   logic [RemW-1:0]   div_rem;

   // scan decode
   logic              size_bad_now;
   logic              is_add, is_kill;
   logic              rd_used, id_hit, kill_hit, scan_used;
   logic              close_en;
   logic [IdxW-1:0]   close_start;
   logic [CntW-1:0]   close_len;
   logic              run_fits, run_better, take_run;
   logic              found_now;
   logic [IdxW-1:0]   best_start_now;
   logic [CntW-1:0]   best_len_now;
   logic [RemW-1:0]   loss;
   logic [FRAG_W:0]   frag_sum;

   bwfa_ram #(
      .WIDTH ($bits(page_entry_type)),
      .DEPTH (PAGES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_entry)
   );

   bwfa_div #(
      .PAGE_KB (PAGE_KB)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req.size_kb),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign size_bad_now = (req.size_kb == '0) || (32'(req.size_kb) > MaxKb);
   assign is_add       = req_ff.kind == KIND_ADD;
   assign is_kill      = req_ff.kind == KIND_KILL;

   // an entry never written reads as free
   assign rd_used   = valid_ff[d_idx_ff] & rd_entry.used;
   assign id_hit    = rd_used && (rd_entry.owner == req_ff.prog_id);
   assign kill_hit  = (state_ff == ENG_SCAN) && dv_ff && is_kill && id_hit;
   assign scan_used = rd_used && !(is_kill && id_hit);

   // close a free run on its first used page, or at the end of the table
   always_comb begin
      close_en    = 1'b0;
      close_start = run_start_ff;
      close_len   = run_len_ff;
      if (state_ff == ENG_SCAN) begin
         close_en = dv_ff && scan_used && !prev_used_ff;
      end else if (state_ff == ENG_LAST) begin
         close_en = !prev_used_ff;
      end
   end

   assign run_fits   = CmpW'(close_len) >= CmpW'(need_ff);
   assign run_better = !found_ff ||
                       (ctl.fit_mode ? (close_len > best_len_ff) : (close_len < best_len_ff));
   assign take_run   = close_en && is_add && !bad_ff && run_fits && run_better;

   assign found_now      = found_ff | take_run;
   assign best_start_now = take_run ? close_start : best_start_ff;
   assign best_len_now   = take_run ? close_len : best_len_ff;

   assign loss     = (div_rem != '0) ? RemW'(PAGE_KB) - div_rem : '0;
   assign frag_sum = {1'b0, frag_ff} + (FRAG_W+1)'(loss);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            if (ctl.start) begin
               state_in = (req.kind == KIND_ADD && !size_bad_now) ? ENG_DIV : ENG_SCAN;
            end
         end
         ENG_DIV: begin
            if (div_done) begin
               state_in = ENG_SCAN;
            end
         end
         ENG_SCAN: begin
            if (dv_ff && d_last_ff) begin
               state_in = ENG_LAST;
            end
         end
         ENG_LAST: begin
            state_in = (is_add && !bad_ff && !present_ff && found_now) ? ENG_WRITE : ENG_DONE;
         end
         ENG_WRITE: begin
            if (wr_left_ff == CntW'(1)) begin
               state_in = ENG_DONE;
            end
         end
         ENG_DONE: begin
            if (ctl.take) begin
               state_in = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      div_start   = (state_ff == ENG_IDLE) && ctl.start && (req.kind == KIND_ADD) &&
                    !size_bad_now;
      ram_rd_addr = rd_idx_ff[IdxW-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = d_idx_ff;
      ram_wr_data = '{used: 1'b0, owner: rd_entry.owner};
      if (state_ff == ENG_SCAN) begin
         ram_wr_en = kill_hit;
      end else if (state_ff == ENG_WRITE) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = wr_ptr_ff;
         ram_wr_data = '{used: 1'b1, owner: req_ff.prog_id};
      end
      stat.ready = state_ff == ENG_IDLE;
      stat.done  = state_ff == ENG_DONE;
   end

   // datapath
   always_comb begin
      req_in        = req_ff;
      bad_in        = bad_ff;
      need_in       = need_ff;
      frag_in       = frag_ff;
      rd_idx_in     = rd_idx_ff;
      dv_in         = 1'b0;
      d_idx_in      = d_idx_ff;
      d_last_in     = d_last_ff;
      prev_used_in  = prev_used_ff;
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      runs_in       = runs_ff;
      found_in      = found_now;
      best_start_in = best_start_now;
      best_len_in   = best_len_now;
      present_in    = present_ff;
      kcount_in     = kcount_ff;
      kstart_in     = kstart_ff;
      wr_ptr_in     = wr_ptr_ff;
      wr_left_in    = wr_left_ff;
      status_in     = status_ff;
      start_pg_in   = start_pg_ff;
      count_in      = count_ff;
      runs_out_in   = runs_out_ff;

      unique case (state_ff)
         ENG_IDLE: begin
            if (ctl.start) begin
               req_in       = req;
               bad_in       = size_bad_now;
               need_in      = '0;
               rd_idx_in    = '0;
               prev_used_in = 1'b1;
               run_len_in   = '0;
               runs_in      = '0;
               found_in     = 1'b0;
               best_len_in  = '0;
               present_in   = 1'b0;
               kcount_in    = '0;
               kstart_in    = '0;
            end
         end
         ENG_DIV: begin
            if (div_done) begin
               need_in = NeedW'(div_quot) + NeedW'(div_rem != '0);
               frag_in = frag_sum[FRAG_W] ? '1 : frag_sum[FRAG_W-1:0];
            end
         end
         ENG_SCAN: begin
            // issue the next read
            if (rd_idx_ff < CntW'(PAGES)) begin
               dv_in     = 1'b1;
               d_idx_in  = rd_idx_ff[IdxW-1:0];
               d_last_in = rd_idx_ff == CntW'(PAGES - 1);
               rd_idx_in = rd_idx_ff + CntW'(1);
            end
            // consume the entry read last cycle
            if (dv_ff) begin
               present_in   = present_ff | id_hit;
               prev_used_in = scan_used;
               if (kill_hit) begin
                  kcount_in = kcount_ff + CntW'(1);
                  if (kcount_ff == '0) begin
                     kstart_in = d_idx_ff;
                  end
               end
               if (!scan_used) begin
                  if (prev_used_ff) begin
                     runs_in      = runs_ff + CntW'(1);
                     run_start_in = d_idx_ff;
                     run_len_in   = CntW'(1);
                  end else begin
                     run_len_in = run_len_ff + CntW'(1);
                  end
               end
            end
         end
         ENG_LAST: begin
            status_in   = STATUS_OK;
            start_pg_in = '0;
            count_in    = '0;
            runs_out_in = RUNS_W'(runs_ff);
            if (is_add) begin
               if (bad_ff) begin
                  status_in = STATUS_BAD_SIZE;
               end else if (present_ff) begin
                  status_in = STATUS_RUNNING;
               end else if (!found_now) begin
                  status_in = STATUS_NO_SPACE;
               end else begin
                  start_pg_in = PAGE_W'(CntW'(best_start_now) + CntW'(1));
                  count_in    = PAGE_W'(need_ff);
                  // an exact fit removes the run
                  runs_out_in = RUNS_W'(runs_ff -
                                CntW'(CmpW'(best_len_now) == CmpW'(need_ff)));
                  wr_ptr_in   = best_start_now;
                  wr_left_in  = CntW'(need_ff);
               end
            end else if (is_kill) begin
               if (kcount_ff == '0) begin
                  status_in = STATUS_NOT_FOUND;
               end else begin
                  start_pg_in = PAGE_W'(CntW'(kstart_ff) + CntW'(1));
                  count_in    = PAGE_W'(kcount_ff);
               end
            end
         end
         ENG_WRITE: begin
            wr_ptr_in  = wr_ptr_ff + IdxW'(1);
            wr_left_in = wr_left_ff - CntW'(1);
         end
         ENG_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         frag_ff  <= '0;
         dv_ff    <= 1'b0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         frag_ff  <= frag_in;
         dv_ff    <= dv_in;
         if (ram_wr_en) begin
            valid_ff[ram_wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      bad_ff        <= bad_in;
      need_ff       <= need_in;
      rd_idx_ff     <= rd_idx_in;
      d_idx_ff      <= d_idx_in;
      d_last_ff     <= d_last_in;
      prev_used_ff  <= prev_used_in;
      run_start_ff  <= run_start_in;
      run_len_ff    <= run_len_in;
      runs_ff       <= runs_in;
      found_ff      <= found_in;
      best_start_ff <= best_start_in;
      best_len_ff   <= best_len_in;
      present_ff    <= present_in;
      kcount_ff     <= kcount_in;
      kstart_ff     <= kstart_in;
      wr_ptr_ff     <= wr_ptr_in;
      wr_left_ff    <= wr_left_in;
      status_ff     <= status_in;
      start_pg_ff   <= start_pg_in;
      count_ff      <= count_in;
      runs_out_ff   <= runs_out_in;
   end

   assign result = '{status:           status_ff,
                     start_page:       start_pg_ff,
                     page_count:       count_ff,
                     free_runs:        runs_out_ff,
                     internal_frag_kb: frag_ff};

endmodule

### hdl/best_worst_fit_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// best_worst_fit_page_allocator_unit
// Contiguous page allocator with best-fit or worst-fit placement.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Direction  Carries
//   request   req_valid/req_stall/req_payload  in       add, kill or query
//   response  rsp_valid/rsp_stall/rsp_payload  out      status, pages, runs, loss
//   csr       csr_wr_en/csr_wr_data            in       fit mode, 0 best 1 worst
//
// Flow: one request at a time. Every request makes one pass over the page
// table memory, one read per cycle; the engine then settles the result in
// ENG_LAST and hands it to the response register from ENG_DONE. An add with
// a valid size first passes through the page-size divider and, when placed,
// writes its pages in ENG_WRITE. The engine then returns to idle before it
// accepts the next request. Reset clears the fit mode, the loss total and the
// per-page valid bits; no clearing pass runs. A stalled response sits in the
// output register while the next request is already accepted and worked on;
// the engine holds its finished result until that register frees up.
//
module best_worst_fit_page_allocator_unit
   import bwfa_pkg::*;
#(
   parameter int PAGES   = PAGES_DEF,
   parameter int PAGE_KB = PAGE_KB_DEF
) (
   input  logic    clock,
   input  logic    reset,

   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,

   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload,

   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   logic         fit_mode_ff, fit_mode_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_payload_ff;
   eng_ctl_type  eng_ctl;
   eng_stat_type eng_stat;
   rsp_type      eng_result;
   logic         out_free;
   logic         rsp_load;

   // policy register, to be written only while idle; the block does not enforce this
   assign fit_mode_in = csr_wr_en ? csr_wr_data : fit_mode_ff;

   // hold requests while the engine works on one
   assign req_stall = !eng_stat.ready;

   // output slot is free when empty or drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = eng_stat.done && out_free;

   assign eng_ctl.start    = req_valid && !req_stall;
   assign eng_ctl.take     = out_free;
   assign eng_ctl.fit_mode = fit_mode_ff;

   bwfa_engine #(
      .PAGES   (PAGES),
      .PAGE_KB (PAGE_KB)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .ctl    (eng_ctl),
      .req    (req_payload),
      .stat   (eng_stat),
      .result (eng_result)
   );

   // advance the response register: load a new result, drop a taken one
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fit_mode_ff  <= fit_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff <= eng_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the best/worst fit page allocator. A clocked driver
// feeds add, kill and query requests from a queue, a shadow allocator predicts
// every response at the moment its request is accepted, and a clocked monitor
// compares each response field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import bwfa_pkg::*;

   localparam int PAGES        = PAGES_DEF;
   localparam int PAGE_KB      = PAGE_KB_DEF;
   localparam int RANDOM_COUNT = 250;     // requests per random phase
   localparam int RANDOM_PHASES = 5;
   localparam int TAIL_CYCLES  = 100;     // longer than the slowest add
   localparam int HANG_LIMIT   = 20000;   // cycles without any handshake
   localparam int REPORT_LIMIT = 10;

   // the unnamed kind code, which the block treats as a query
   localparam kind_type KIND_RESERVED = kind_type'(2'd3);

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;

   // requests waiting for the driver, responses waiting for the monitor
   req_type request_queue[$];
   rsp_type expected_responses[$];

   // shadow of the allocator state
   bit            page_taken [PAGES];
   bit [ID_W-1:0] page_holder[PAGES];
   bit [FRAG_W-1:0] loss_total;
   bit            fit_worst;

   // ids that the random requests mostly use, so that kills find their owners
   bit [ID_W-1:0] id_pool[8];

   // turns off idling on both channels for one whole phase
   bit steady = 1'b0;

   int failure_count = 0;
   int hang_count    = 0;

   best_worst_fit_page_allocator_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request to the shadow allocator and return the response it
   // must produce. Call exactly once per accepted request, in order.
   function automatic rsp_type allocator_response(req_type r);
      rsp_type         res;
      int              need;
      int              i;
      int              run_start;
      int              len;
      int              best_start;
      int              best_len;
      int              runs;
      bit              present;
      bit [FRAG_W:0]   sum;
      res = '0;
      res.status = STATUS_OK;
      case (r.kind)
         KIND_ADD: begin
            if (r.size_kb == 0 || int'(r.size_kb) > PAGES * PAGE_KB) begin
               res.status = STATUS_BAD_SIZE;
            end else begin
               need = (int'(r.size_kb) + PAGE_KB - 1) / PAGE_KB;
               // rounding loss counts even when the add is rejected later
               if (int'(r.size_kb) % PAGE_KB != 0) begin
                  sum = (FRAG_W+1)'(loss_total) +
                        (FRAG_W+1)'(PAGE_KB - int'(r.size_kb) % PAGE_KB);
                  loss_total = (sum > {1'b0, {FRAG_W{1'b1}}}) ? {FRAG_W{1'b1}}
                                                               : sum[FRAG_W-1:0];
               end
               present = 1'b0;
               for (i = 0; i < PAGES; i++) begin
                  if (page_taken[i] && page_holder[i] == r.prog_id) present = 1'b1;
               end
               if (present) begin
                  res.status = STATUS_RUNNING;
               end else begin
                  // walk the free runs; ties keep the lowest address
                  best_start = -1;
                  best_len   = 0;
                  i = 0;
                  while (i < PAGES) begin
                     if (page_taken[i]) begin
                        i++;
                     end else begin
                        run_start = i;
                        while (i < PAGES && !page_taken[i]) i++;
                        len = i - run_start;
                        if (len >= need && (best_start < 0 ||
                            (fit_worst ? len > best_len : len < best_len))) begin
                           best_start = run_start;
                           best_len   = len;
                        end
                     end
                  end
                  if (best_start < 0) begin
                     res.status = STATUS_NO_SPACE;
                  end else begin
                     for (i = best_start; i < best_start + need; i++) begin
                        page_taken[i]  = 1'b1;
                        page_holder[i] = r.prog_id;
                     end
                     res.start_page = PAGE_W'(best_start + 1);
                     res.page_count = PAGE_W'(need);
                  end
               end
            end
         end
         KIND_KILL: begin
            for (i = 0; i < PAGES; i++) begin
               if (page_taken[i] && page_holder[i] == r.prog_id) begin
                  if (res.page_count == 0) res.start_page = PAGE_W'(i + 1);
                  res.page_count++;
                  page_taken[i] = 1'b0;
               end
            end
            if (res.page_count == 0) res.status = STATUS_NOT_FOUND;
         end
         default: begin
            // query and the reserved kind change nothing
         end
      endcase
      runs = 0;
      for (i = 0; i < PAGES; i++) begin
         if (!page_taken[i] && (i == 0 || page_taken[i > 0 ? i - 1 : 0])) runs++;
      end
      res.free_runs        = RUNS_W'(runs);
      res.internal_frag_kb = loss_total;
      return res;
   endfunction

   // Random request, mostly well formed: pool ids, sizes that mostly fit.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 50)      r.kind = KIND_ADD;
      else if (pick < 85) r.kind = KIND_KILL;
      else if (pick < 95) r.kind = KIND_QUERY;
      else                r.kind = KIND_RESERVED;
      if ($urandom_range(99) < 10) r.prog_id = ID_W'($urandom_range(255));
      else                         r.prog_id = id_pool[$urandom_range(7)];
      pick = $urandom_range(99);
      if (pick < 60)      r.size_kb = SIZE_W'($urandom_range(16, 1));
      else if (pick < 85) r.size_kb = SIZE_W'($urandom_range(64, 17));
      else if (pick < 95) r.size_kb = SIZE_W'($urandom_range(PAGES * PAGE_KB, 65));
      else if (pick < 97) r.size_kb = '0;
      else                r.size_kb = SIZE_W'($urandom_range(255, PAGES * PAGE_KB + 1));
      return r;
   endfunction

   task automatic queue_request(kind_type kind, int id, int size);
      req_type r;
      r.kind    = kind;
      r.prog_id = ID_W'(id);
      r.size_kb = SIZE_W'(size);
      request_queue.push_back(r);
   endtask

   // Hold until every queued request went in and every response came back.
   // Sample away from the rising edge so the driver's updates have settled.
   task automatic drain();
      while (request_queue.size() != 0 || req_valid || expected_responses.size() != 0)
         @(negedge clock);
   endtask

   // Write the fit mode while the block is idle and mirror it in the shadow.
   task automatic write_fit_mode(bit mode);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      fit_worst    = mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Driver: predict on acceptance, hold a stalled request, then either
   // present the next pending request or leave the request channel idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_responses.push_back(allocator_response(req_payload));
         end
         if (!req_valid || !req_stall) begin
            if (request_queue.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
               req_valid   <= 1'b1;
               req_payload <= request_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted response against the oldest prediction,
   // and stall the response channel at random.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               failure_count++;
               if (failure_count <= REPORT_LIMIT)
                  $display({"unexpected response: status %0d start %0d count %0d",
                            " runs %0d loss %0d"},
                           rsp_payload.status, rsp_payload.start_page,
                           rsp_payload.page_count, rsp_payload.free_runs,
                           rsp_payload.internal_frag_kb);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_payload.status !== want.status ||
                   rsp_payload.start_page !== want.start_page ||
                   rsp_payload.page_count !== want.page_count ||
                   rsp_payload.free_runs !== want.free_runs ||
                   rsp_payload.internal_frag_kb !== want.internal_frag_kb) begin
                  failure_count++;
                  if (failure_count <= REPORT_LIMIT)
                     $display({"mismatch: expected status %0d start %0d count %0d",
                               " runs %0d loss %0d, got status %0d start %0d",
                               " count %0d runs %0d loss %0d"},
                              want.status, want.start_page, want.page_count,
                              want.free_runs, want.internal_frag_kb,
                              rsp_payload.status, rsp_payload.start_page,
                              rsp_payload.page_count, rsp_payload.free_runs,
                              rsp_payload.internal_frag_kb);
               end
            end
         end
         rsp_stall <= !steady && ($urandom_range(99) < 15);
      end
   end

   // Watchdog: abort when no handshake happens on either channel for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            hang_count <= 0;
         end else if (hang_count >= HANG_LIMIT) begin
            $display("[best_worst_fit_page_allocator_unit] ERROR");
            $finish;
         end else begin
            hang_count <= hang_count + 1;
         end
      end
   end

   initial begin
      int p;
      int k;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part, best fit
      write_fit_mode(1'b0);
      queue_request(KIND_QUERY, 1, 0);
      queue_request(KIND_RESERVED, 1, 0);
      queue_request(KIND_ADD, 1, 0);                     // zero size
      queue_request(KIND_ADD, 1, PAGES * PAGE_KB + 1);   // just above capacity
      queue_request(KIND_ADD, 1, 255);
      queue_request(KIND_ADD, 1, PAGES * PAGE_KB);       // fill the whole memory
      queue_request(KIND_ADD, 2, 1);                     // full memory, loss counted
      queue_request(KIND_ADD, 1, 4);                     // already running
      queue_request(KIND_KILL, 255, 0);                  // absent id
      queue_request(KIND_KILL, 1, 0);
      queue_request(KIND_ADD, 0, 5);                     // id zero
      queue_request(KIND_ADD, 8'hAA, 8);
      queue_request(KIND_ADD, 8'h55, 12);
      queue_request(KIND_ADD, 8'h80, 3);
      queue_request(KIND_KILL, 8'hAA, 0);                // open a two-page hole
      queue_request(KIND_ADD, 7, 4);                     // best fit takes the hole
      queue_request(KIND_KILL, 0, 0);
      queue_request(KIND_ADD, 8'hFF, 127);               // no run large enough
      queue_request(KIND_QUERY, 0, 0);
      queue_request(KIND_KILL, 8'h55, 0);
      queue_request(KIND_KILL, 8'h80, 0);
      queue_request(KIND_KILL, 7, 0);
      queue_request(KIND_QUERY, 8'hFF, 8'hFF);
      drain();

      // random phases, alternating worst and best fit; one runs without idling
      for (p = 0; p < RANDOM_PHASES; p++) begin
         write_fit_mode(p % 2 == 0);
         steady = (p == 2);
         for (k = 0; k < 8; k++) id_pool[k] = ID_W'($urandom_range(255));
         for (k = 0; k < RANDOM_COUNT; k++) request_queue.push_back(random_request());
         drain();
         steady = 1'b0;
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_responses.size() != 0) failure_count++;
      if (failure_count == 0) begin
         $display("[best_worst_fit_page_allocator_unit] OK");
      end else begin
         $display("[best_worst_fit_page_allocator_unit] ERROR");
      end
      $finish;
   end

endmodule
